// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SLPS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define SLPS_ASSERT_NEVER(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("%m: forbidden condition seen");
`else
`define SLPS_ASSERT(lbl, clk, rst_n, prop)
`define SLPS_ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif

`endif

// ----- rtl/slps_pkg.sv -----
package slps_pkg;

  localparam int unsigned PWM_PERIOD_DEF = 2000;
  localparam int unsigned CMP_W          = 11;
  localparam int unsigned ST_W           = 5;
  localparam int unsigned CNT_W          = 8;
  localparam int unsigned FLASH_W        = 3;
  localparam int unsigned CFG_IDX_W      = 3;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [ST_W-1:0] ST_IDLE       = 5'd0;
  localparam logic [ST_W-1:0] ST_CHARGING   = 5'd1;
  localparam logic [ST_W-1:0] ST_FULLCHARGE = 5'd2;
  localparam logic [ST_W-1:0] ST_NTC        = 5'd4;
  localparam logic [ST_W-1:0] ST_BAT_HIGH   = 5'd5;
  localparam logic [ST_W-1:0] ST_BAT_MID    = 5'd6;
  localparam logic [ST_W-1:0] ST_BAT_LOW    = 5'd7;
  localparam logic [ST_W-1:0] ST_BAT_WARN   = 5'd8;
  localparam logic [ST_W-1:0] ST_CHG_EAR    = 5'd9;
  localparam logic [ST_W-1:0] ST_EAR_FULL   = 5'd10;
  localparam logic [ST_W-1:0] ST_EAR_OC     = 5'd11;
  localparam logic [ST_W-1:0] ST_PTP_PAIR   = 5'd12;
  localparam logic [ST_W-1:0] ST_BT_PAIR    = 5'd13;
  localparam logic [ST_W-1:0] ST_EAR_RESET  = 5'd14;
  localparam logic [ST_W-1:0] ST_FREEMAN    = 5'd15;
  localparam logic [ST_W-1:0] ST_MAX        = 5'd16;

  localparam logic [FLASH_W-1:0] NTC_FLASHES  = 3'd3;
  localparam logic [FLASH_W-1:0] WARN_FLASHES = 3'd5;

  localparam logic [1:0] DRV_OFF   = 2'd0;
  localparam logic [1:0] DRV_SOLID = 2'd1;
  localparam logic [1:0] DRV_PWM   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BREATH_RESTART = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_HOLD   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAIR_HOLD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_OFF       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIDDLE_GREEN   = 3'd5;

  typedef struct packed {
    logic [CNT_W-1:0] breath_restart;
    logic [CNT_W-1:0] battery_hold;
    logic [CNT_W-1:0] pair_hold;
    logic [CNT_W-1:0] blink;
    logic [CNT_W-1:0] long_off;
    logic [CMP_W-1:0] middle_green;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    breath_restart: 8'd30,
    battery_hold:   8'd20,
    pair_hold:      8'd10,
    blink:          8'd2,
    long_off:       8'd50,
    middle_green:   11'd1680
  };

  typedef struct packed {
    logic [1:0]       red;
    logic [1:0]       green;
    logic             blue;
    logic [CMP_W-1:0] cmp;
    logic             breath;
  } drv_t;

  localparam drv_t DRV_ALL_OFF = '{
    red: DRV_OFF, green: DRV_OFF, blue: 1'b0, cmp: '0, breath: 1'b0
  };

  typedef struct packed {
    logic [ST_W-1:0]    cur;
    logic [ST_W-1:0]    prev;
    logic [CNT_W-1:0]   tcnt;
    logic               phase_on;
    logic [FLASH_W-1:0] flash;
    drv_t               drv;
  } seq_state_t;

  localparam seq_state_t STATE_RESET = '{
    cur: ST_IDLE, prev: ST_IDLE, tcnt: '0, phase_on: 1'b0, flash: '0, drv: DRV_ALL_OFF
  };

endpackage

// ----- rtl/status_led_pattern_sequencer.sv -----
// Status LED pattern sequencer.
// A beat goes from the input register to the output register, which drives out_valid.
// Throughput: one beat per cycle while out_stall is low; the status/counter update is combinational.
// Reset (rst_n low, synchronous): status idle, counters zero, internal LED drive off,
// PWM stopped, configuration back to defaults, both pipeline stages empty.
`include "assert_macros.svh"

module status_led_pattern_sequencer #(
  parameter int unsigned PWM_PERIOD = slps_pkg::PWM_PERIOD_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [slps_pkg::ST_W-1:0]       in_status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_set_changed,
  output logic [1:0]                      out_red_drive,
  output logic [1:0]                      out_green_drive,
  output logic                            out_blue_on,
  output logic [slps_pkg::CMP_W-1:0]      out_pwm_compare,
  output logic                            out_breath_enable,
  output logic [slps_pkg::ST_W-1:0]       out_status_now,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slps_pkg::CMP_W-1:0]      cfg_data
);

  localparam logic [15:0] PERIOD16 = 16'(PWM_PERIOD);
  localparam logic [slps_pkg::CMP_W-1:0] PERIOD_CMP = PERIOD16[slps_pkg::CMP_W-1:0];

  slps_pkg::cfg_t        cfg;
  slps_pkg::seq_state_t  st_r;
  slps_pkg::seq_state_t  st_nxt;
  logic                  changed;

  logic                        in_v_r;
  logic                        in_v_nxt;
  logic                        in_kind_r;
  logic [slps_pkg::ST_W-1:0]   in_status_r;
  logic                        out_v_r;
  logic                        out_v_nxt;
  logic                        out_changed_r;
  slps_pkg::drv_t              out_drv_r;
  logic [slps_pkg::ST_W-1:0]   out_status_r;

  logic adv;
  logic in_take;

  assign cfg_ready = 1'b1;

  slps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  slps_step #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_step (
    .cfg     (cfg),
    .st      (st_r),
    .kind    (in_kind_r),
    .req     (in_status_r),
    .st_nxt  (st_nxt),
    .changed (changed)
  );

  assign adv      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (adv) begin
      in_v_nxt = 1'b0;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (adv) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= slps_pkg::STATE_RESET;
    end else begin
      in_v_r  <= in_v_nxt;
      out_v_r <= out_v_nxt;
      if (adv) st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_kind_r   <= in_kind;
      in_status_r <= in_status;
    end
    if (adv) begin
      out_changed_r <= changed;
      out_drv_r     <= st_nxt.drv;
      out_status_r  <= st_nxt.cur;
    end
  end

  assign out_valid         = out_v_r;
  assign out_set_changed   = out_changed_r;
  assign out_red_drive     = out_drv_r.red;
  assign out_green_drive   = out_drv_r.green;
  assign out_blue_on       = out_drv_r.blue;
  assign out_pwm_compare   = out_drv_r.cmp;
  assign out_breath_enable = out_drv_r.breath;
  assign out_status_now    = out_status_r;

  `SLPS_ASSERT_NEVER(a_no_overwrite, clk, rst_n, adv && out_v_r && out_stall)
  `SLPS_ASSERT(a_status_range, clk, rst_n, st_r.cur <= slps_pkg::ST_MAX)
  `SLPS_ASSERT(a_flash_range, clk, rst_n, st_r.flash < slps_pkg::WARN_FLASHES)
  `SLPS_ASSERT(a_breath_cmp, clk, rst_n, st_r.drv.breath |-> st_r.drv.cmp == PERIOD_CMP)
  `SLPS_ASSERT(a_tick_no_change, clk, rst_n, adv && in_kind_r == slps_pkg::KIND_TICK |=> !out_changed_r)

endmodule

// ----- rtl/slps_cfg_regs.sv -----
module slps_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [slps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [slps_pkg::CMP_W-1:0]      cfg_data,
  output slps_pkg::cfg_t                  cfg
);

  slps_pkg::cfg_t cfg_r;
  slps_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        slps_pkg::REG_BREATH_RESTART: cfg_nxt.breath_restart = cfg_data[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_BATTERY_HOLD:   cfg_nxt.battery_hold   = cfg_data[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_PAIR_HOLD:      cfg_nxt.pair_hold      = cfg_data[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_BLINK:          cfg_nxt.blink          = cfg_data[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_LONG_OFF:       cfg_nxt.long_off       = cfg_data[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_MIDDLE_GREEN:   cfg_nxt.middle_green   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= slps_pkg::CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/slps_step.sv -----
module slps_step #(
  parameter int unsigned PWM_PERIOD = slps_pkg::PWM_PERIOD_DEF
) (
  input  slps_pkg::cfg_t                 cfg,
  input  slps_pkg::seq_state_t           st,
  input  logic                           kind,
  input  logic [slps_pkg::ST_W-1:0]      req,
  output slps_pkg::seq_state_t           st_nxt,
  output logic                           changed
);

  localparam logic [15:0] PERIOD16 = 16'(PWM_PERIOD);
  localparam logic [slps_pkg::CMP_W-1:0] PERIOD_CMP = PERIOD16[slps_pkg::CMP_W-1:0];

  logic                          first;
  logic [slps_pkg::CNT_W-1:0]    cnt_up;
  logic [slps_pkg::CNT_W-1:0]    off_len;
  logic [slps_pkg::FLASH_W-1:0]  flash_inc;
  logic [slps_pkg::CMP_W-1:0]    mid_cmp;

  assign first     = (st.cur != st.prev);
  assign cnt_up    = (st.tcnt == '1) ? st.tcnt : st.tcnt + 8'd1;
  assign off_len   = (st.cur == slps_pkg::ST_CHG_EAR) ? cfg.long_off : cfg.blink;
  assign flash_inc = st.flash + 3'd1;
  assign mid_cmp   = ({5'd0, cfg.middle_green} > PERIOD16) ? PERIOD_CMP : cfg.middle_green;

  always_comb begin
    st_nxt  = st;
    changed = 1'b0;
    if (kind == slps_pkg::KIND_SET) begin
      if (req <= slps_pkg::ST_MAX && req != st.cur) begin
        st_nxt.cur = req;
        st_nxt.drv = slps_pkg::DRV_ALL_OFF;
        changed    = 1'b1;
      end
    end else begin
      st_nxt.prev = st.cur;
      case (st.cur) inside
        slps_pkg::ST_CHARGING, slps_pkg::ST_FULLCHARGE: begin
          if (!first) st_nxt.tcnt = cnt_up;
          if (first || cnt_up >= cfg.breath_restart) begin
            st_nxt.tcnt       = '0;
            st_nxt.drv.cmp    = PERIOD_CMP;
            st_nxt.drv.breath = 1'b1;
            if (st.cur == slps_pkg::ST_CHARGING) begin
              st_nxt.drv.red   = slps_pkg::DRV_PWM;
              st_nxt.drv.green = slps_pkg::DRV_OFF;
            end else begin
              st_nxt.drv.red   = slps_pkg::DRV_OFF;
              st_nxt.drv.green = slps_pkg::DRV_PWM;
            end
          end
        end
        slps_pkg::ST_NTC: begin
          if (first) begin
            st_nxt.tcnt     = '0;
            st_nxt.flash    = '0;
            st_nxt.phase_on = 1'b1;
            st_nxt.drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            st_nxt.tcnt = cnt_up;
            if (st.flash < slps_pkg::NTC_FLASHES) begin
              if (cnt_up >= cfg.blink) begin
                st_nxt.tcnt = '0;
                if (!st.phase_on) begin
                  st_nxt.phase_on = 1'b1;
                  st_nxt.drv.red  = slps_pkg::DRV_SOLID;
                end else begin
                  st_nxt.phase_on = 1'b0;
                  st_nxt.flash    = flash_inc;
                  st_nxt.drv      = slps_pkg::DRV_ALL_OFF;
                end
              end
            end else if (cnt_up >= cfg.pair_hold) begin
              st_nxt.flash = '0;
            end
          end
        end
        slps_pkg::ST_BAT_HIGH, slps_pkg::ST_BAT_MID, slps_pkg::ST_BAT_LOW: begin
          if (first) begin
            st_nxt.tcnt = '0;
            if (st.cur == slps_pkg::ST_BAT_HIGH) begin
              st_nxt.drv.green = slps_pkg::DRV_SOLID;
            end else if (st.cur == slps_pkg::ST_BAT_MID) begin
              st_nxt.drv.green  = slps_pkg::DRV_PWM;
              st_nxt.drv.red    = slps_pkg::DRV_SOLID;
              st_nxt.drv.cmp    = mid_cmp;
              st_nxt.drv.breath = 1'b0;
            end else begin
              st_nxt.drv.red = slps_pkg::DRV_SOLID;
            end
          end else begin
            st_nxt.tcnt = cnt_up;
            if (cnt_up >= cfg.battery_hold) begin
              st_nxt.tcnt = '0;
              st_nxt.drv  = slps_pkg::DRV_ALL_OFF;
              st_nxt.cur  = slps_pkg::ST_IDLE;
            end
          end
        end
        slps_pkg::ST_BAT_WARN: begin
          if (first) begin
            st_nxt.tcnt     = '0;
            st_nxt.flash    = '0;
            st_nxt.phase_on = 1'b1;
            st_nxt.drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            st_nxt.tcnt = cnt_up;
            if (cnt_up >= cfg.blink) begin
              st_nxt.tcnt = '0;
              if (!st.phase_on) begin
                st_nxt.phase_on = 1'b1;
                st_nxt.drv.red  = slps_pkg::DRV_SOLID;
              end else begin
                st_nxt.phase_on = 1'b0;
                st_nxt.drv      = slps_pkg::DRV_ALL_OFF;
                if (flash_inc >= slps_pkg::WARN_FLASHES) begin
                  st_nxt.flash = '0;
                  st_nxt.cur   = slps_pkg::ST_IDLE;
                end else begin
                  st_nxt.flash = flash_inc;
                end
              end
            end
          end
        end
        slps_pkg::ST_CHG_EAR, slps_pkg::ST_EAR_OC: begin
          if (first) begin
            st_nxt.tcnt     = '0;
            st_nxt.phase_on = 1'b1;
            st_nxt.drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            st_nxt.tcnt = cnt_up;
            if (!st.phase_on && cnt_up >= off_len) begin
              st_nxt.tcnt     = '0;
              st_nxt.phase_on = 1'b1;
              st_nxt.drv.red  = slps_pkg::DRV_SOLID;
            end else if (st.phase_on && cnt_up >= cfg.blink) begin
              st_nxt.tcnt     = '0;
              st_nxt.phase_on = 1'b0;
              st_nxt.drv      = slps_pkg::DRV_ALL_OFF;
            end
          end
        end
        slps_pkg::ST_EAR_FULL: begin
          if (first) begin
            st_nxt.tcnt = '0;
            st_nxt.drv  = slps_pkg::DRV_ALL_OFF;
          end
        end
        slps_pkg::ST_PTP_PAIR, slps_pkg::ST_BT_PAIR, slps_pkg::ST_EAR_RESET,
        slps_pkg::ST_FREEMAN: begin
          if (first) begin
            st_nxt.tcnt     = '0;
            st_nxt.drv.blue = 1'b1;
          end else begin
            st_nxt.tcnt = cnt_up;
            if (cnt_up >= cfg.pair_hold) begin
              st_nxt.tcnt = '0;
              st_nxt.drv  = slps_pkg::DRV_ALL_OFF;
              st_nxt.cur  = slps_pkg::ST_IDLE;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- dv/tb_status_led_pattern_sequencer.sv -----
module tb_status_led_pattern_sequencer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [slps_pkg::CMP_W-1:0] field_t;
  typedef logic [slps_pkg::ST_W-1:0]  st_code_t;

  localparam int TICK_BEAT       = 32;
  localparam int BEATS_PER_PHASE = 85;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LAST_PHASE      = 5;

  localparam logic [slps_pkg::ST_W-1:0]      ST_OUT_OF_RANGE = slps_pkg::ST_MAX + 5'd1;
  localparam logic [slps_pkg::ST_W-1:0]      ST_ALL_ONES     = '1;
  localparam logic [slps_pkg::CFG_IDX_W-1:0] REG_SPARE_6     = 3'd6;
  localparam logic [slps_pkg::CFG_IDX_W-1:0] REG_SPARE_7     = 3'd7;

  typedef struct {
    logic                       set_changed;
    logic [1:0]                 red;
    logic [1:0]                 green;
    logic                       blue;
    logic [slps_pkg::CMP_W-1:0] cmp;
    logic                       breath;
    logic [slps_pkg::ST_W-1:0]  status;
  } led_result_t;

  class led_pattern_scoreboard;
    slps_pkg::cfg_t               regs;
    logic [slps_pkg::ST_W-1:0]    cur_st;
    logic [slps_pkg::ST_W-1:0]    prev_st;
    int unsigned                  ticks;
    bit                           phase_on;
    logic [slps_pkg::FLASH_W-1:0] flashes;
    slps_pkg::drv_t               drv;
    led_result_t                  expected_leds[$];
    int                           mismatches;

    function new();
      regs       = slps_pkg::CFG_RESET;
      cur_st     = slps_pkg::ST_IDLE;
      prev_st    = slps_pkg::ST_IDLE;
      ticks      = 0;
      phase_on   = 1'b0;
      flashes    = '0;
      drv        = slps_pkg::DRV_ALL_OFF;
      mismatches = 0;
    endfunction

    function void write_reg(logic [slps_pkg::CFG_IDX_W-1:0] idx,
                            logic [slps_pkg::CMP_W-1:0] val);
      case (idx)
        slps_pkg::REG_BREATH_RESTART: regs.breath_restart = val[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_BATTERY_HOLD:   regs.battery_hold   = val[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_PAIR_HOLD:      regs.pair_hold      = val[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_BLINK:          regs.blink          = val[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_LONG_OFF:       regs.long_off       = val[slps_pkg::CNT_W-1:0];
        slps_pkg::REG_MIDDLE_GREEN:   regs.middle_green   = val;
        default: ;
      endcase
    endfunction

    function void all_off();
      drv = slps_pkg::DRV_ALL_OFF;
    endfunction

    function void bump();
      if (ticks < 255) ticks++;
    endfunction

    function void run_tick();
      logic [slps_pkg::ST_W-1:0]  st;
      bit                         first;
      bit                         restart;
      logic [slps_pkg::CNT_W-1:0] off_len;
      st    = cur_st;
      first = (st != prev_st);
      case (st)
        slps_pkg::ST_CHARGING, slps_pkg::ST_FULLCHARGE: begin
          restart = first;
          if (!first) begin
            bump();
            restart = (ticks >= regs.breath_restart);
          end
          if (restart) begin
            ticks      = 0;
            drv.red    = (st == slps_pkg::ST_CHARGING) ? slps_pkg::DRV_PWM : slps_pkg::DRV_OFF;
            drv.green  = (st == slps_pkg::ST_CHARGING) ? slps_pkg::DRV_OFF : slps_pkg::DRV_PWM;
            drv.cmp    = field_t'(slps_pkg::PWM_PERIOD_DEF);
            drv.breath = 1'b1;
          end
        end
        slps_pkg::ST_NTC: begin
          if (first) begin
            ticks    = 0;
            flashes  = '0;
            phase_on = 1'b1;
            drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            bump();
            if (flashes < slps_pkg::NTC_FLASHES) begin
              if (ticks >= regs.blink) begin
                ticks = 0;
                if (!phase_on) begin
                  phase_on = 1'b1;
                  drv.red  = slps_pkg::DRV_SOLID;
                end else begin
                  phase_on = 1'b0;
                  flashes++;
                  all_off();
                end
              end
            end else if (ticks >= regs.pair_hold) begin
              flashes = '0;
            end
          end
        end
        slps_pkg::ST_BAT_HIGH, slps_pkg::ST_BAT_MID, slps_pkg::ST_BAT_LOW: begin
          if (first) begin
            ticks = 0;
            if (st == slps_pkg::ST_BAT_HIGH) begin
              drv.green = slps_pkg::DRV_SOLID;
            end else begin
              if (st == slps_pkg::ST_BAT_MID) begin
                drv.green  = slps_pkg::DRV_PWM;
                drv.cmp    = (regs.middle_green > slps_pkg::PWM_PERIOD_DEF)
                             ? field_t'(slps_pkg::PWM_PERIOD_DEF) : regs.middle_green;
                drv.breath = 1'b0;
              end
              drv.red = slps_pkg::DRV_SOLID;
            end
          end else begin
            bump();
            if (ticks >= regs.battery_hold) begin
              ticks  = 0;
              all_off();
              cur_st = slps_pkg::ST_IDLE;
            end
          end
        end
        slps_pkg::ST_BAT_WARN: begin
          if (first) begin
            ticks    = 0;
            flashes  = '0;
            phase_on = 1'b1;
            drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            bump();
            if (ticks >= regs.blink) begin
              ticks = 0;
              if (!phase_on) begin
                phase_on = 1'b1;
                drv.red  = slps_pkg::DRV_SOLID;
              end else begin
                phase_on = 1'b0;
                flashes++;
                if (flashes >= slps_pkg::WARN_FLASHES) begin
                  flashes = '0;
                  cur_st  = slps_pkg::ST_IDLE;
                end
                all_off();
              end
            end
          end
        end
        slps_pkg::ST_CHG_EAR, slps_pkg::ST_EAR_OC: begin
          if (first) begin
            ticks    = 0;
            phase_on = 1'b1;
            drv.red  = slps_pkg::DRV_SOLID;
          end else begin
            off_len = (st == slps_pkg::ST_CHG_EAR) ? regs.long_off : regs.blink;
            bump();
            if (!phase_on && ticks >= off_len) begin
              ticks    = 0;
              phase_on = 1'b1;
              drv.red  = slps_pkg::DRV_SOLID;
            end else if (phase_on && ticks >= regs.blink) begin
              ticks    = 0;
              phase_on = 1'b0;
              all_off();
            end
          end
        end
        slps_pkg::ST_EAR_FULL: begin
          if (first) begin
            ticks = 0;
            all_off();
          end
        end
        slps_pkg::ST_PTP_PAIR, slps_pkg::ST_BT_PAIR, slps_pkg::ST_EAR_RESET,
        slps_pkg::ST_FREEMAN: begin
          if (first) begin
            ticks    = 0;
            drv.blue = 1'b1;
          end else begin
            bump();
            if (ticks >= regs.pair_hold) begin
              ticks  = 0;
              all_off();
              cur_st = slps_pkg::ST_IDLE;
            end
          end
        end
        default: ;
      endcase
      prev_st = st;
    endfunction

    function void predict_beat(logic kind, logic [slps_pkg::ST_W-1:0] req);
      led_result_t exp;
      exp.set_changed = 1'b0;
      if (kind == slps_pkg::KIND_SET) begin
        if (req <= slps_pkg::ST_MAX && req != cur_st) begin
          cur_st = req;
          all_off();
          exp.set_changed = 1'b1;
        end
      end else begin
        run_tick();
      end
      exp.red    = drv.red;
      exp.green  = drv.green;
      exp.blue   = drv.blue;
      exp.cmp    = drv.cmp;
      exp.breath = drv.breath;
      exp.status = cur_st;
      expected_leds.push_back(exp);
    endfunction

    function void check_field(string fname, field_t exp, field_t got);
      if (got !== exp) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp, got);
      end
    endfunction

    function void check_leds(led_result_t got);
      led_result_t exp;
      if (expected_leds.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected", $time);
        return;
      end
      exp = expected_leds.pop_front();
      check_field("set_changed", field_t'(exp.set_changed), field_t'(got.set_changed));
      check_field("red_drive", field_t'(exp.red), field_t'(got.red));
      check_field("green_drive", field_t'(exp.green), field_t'(got.green));
      check_field("blue_on", field_t'(exp.blue), field_t'(got.blue));
      check_field("pwm_compare", exp.cmp, got.cmp);
      check_field("breath_enable", field_t'(exp.breath), field_t'(got.breath));
      check_field("status_now", field_t'(exp.status), field_t'(got.status));
    endfunction
  endclass

  logic                           clk;
  logic                           rst_n             = 1'b0;
  logic                           in_valid          = 1'b0;
  logic                           in_stall;
  logic                           in_kind           = slps_pkg::KIND_SET;
  logic [slps_pkg::ST_W-1:0]      in_status         = slps_pkg::ST_IDLE;
  logic                           out_valid;
  logic                           out_stall         = 1'b0;
  logic                           out_set_changed;
  logic [1:0]                     out_red_drive;
  logic [1:0]                     out_green_drive;
  logic                           out_blue_on;
  logic [slps_pkg::CMP_W-1:0]     out_pwm_compare;
  logic                           out_breath_enable;
  logic [slps_pkg::ST_W-1:0]      out_status_now;
  logic                           cfg_valid         = 1'b0;
  logic                           cfg_ready;
  logic [slps_pkg::CFG_IDX_W-1:0] cfg_index         = slps_pkg::REG_BREATH_RESTART;
  logic [slps_pkg::CMP_W-1:0]     cfg_data          = '0;

  led_pattern_scoreboard leds_sb = new();
  int unsigned           beats_sent = 0;
  bit                    quiet_in   = 1'b0;
  bit                    quiet_out  = 1'b0;

  int directed_seq[25] = '{
    ST_ALL_ONES, ST_OUT_OF_RANGE, slps_pkg::ST_MAX, TICK_BEAT, slps_pkg::ST_IDLE,
    slps_pkg::ST_IDLE, TICK_BEAT, slps_pkg::ST_CHARGING, TICK_BEAT, TICK_BEAT,
    slps_pkg::ST_FULLCHARGE, slps_pkg::ST_CHARGING, TICK_BEAT, slps_pkg::ST_BAT_MID, TICK_BEAT,
    TICK_BEAT, slps_pkg::ST_BAT_WARN, TICK_BEAT, TICK_BEAT, TICK_BEAT,
    slps_pkg::ST_EAR_FULL, TICK_BEAT, TICK_BEAT, slps_pkg::ST_NTC, TICK_BEAT
  };

  status_led_pattern_sequencer i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_beat(logic kind, logic [slps_pkg::ST_W-1:0] req);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_kind   <= kind;
    in_status <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    leds_sb.predict_beat(kind, req);
    beats_sent++;
  endtask

  // caller lowers cfg_valid after the last write
  task automatic write_reg(logic [slps_pkg::CFG_IDX_W-1:0] idx,
                           logic [slps_pkg::CMP_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    leds_sb.write_reg(idx, val);
  endtask

  task automatic wait_leds_idle();
    in_valid <= 1'b0;
    while (leds_sb.expected_leds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    led_result_t got;
    int unsigned hold;
    wait (rst_n === 1'b1);
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.set_changed = out_set_changed;
      got.red         = out_red_drive;
      got.green       = out_green_drive;
      got.blue        = out_blue_on;
      got.cmp         = out_pwm_compare;
      got.breath      = out_breath_enable;
      got.status      = out_status_now;
      leds_sb.check_leds(got);
    end
  end

  initial begin : stimulus
    int unsigned                    pick;
    int unsigned                    stop_at;
    logic [slps_pkg::ST_W-1:0]      st;
    logic [slps_pkg::CFG_IDX_W-1:0] r;
    logic [slps_pkg::CMP_W-1:0]     hold_val;
    logic [slps_pkg::CMP_W-1:0]     green_val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_seq[i]) begin
      if (directed_seq[i] == TICK_BEAT) send_beat(slps_pkg::KIND_TICK, ST_ALL_ONES);
      else send_beat(slps_pkg::KIND_SET, st_code_t'(directed_seq[i]));
    end

    for (int ph = 0; ph <= LAST_PHASE; ph++) begin
      wait_leds_idle();
      if (ph > 0) begin
        case (ph)
          1: begin hold_val = 11'd1;   green_val = 11'd0;    end
          2: begin hold_val = 11'd255; green_val = '1;       end
          3: begin hold_val = 11'h700; green_val = 11'd2000; end
          default: begin
            hold_val  = 11'd1;
            green_val = field_t'($urandom_range(0, 2047));
          end
        endcase
        for (r = slps_pkg::REG_BREATH_RESTART; r <= slps_pkg::REG_LONG_OFF; r++)
          write_reg(r, (ph > 3) ? 11'($urandom_range(1, 6)) : hold_val);
        write_reg(slps_pkg::REG_MIDDLE_GREEN, green_val);
        if (ph == 3) begin
          write_reg(REG_SPARE_6, '1);
          write_reg(REG_SPARE_7, '1);
        end
        cfg_valid <= 1'b0;
      end
      quiet_in  = ($urandom_range(0, 2) == 0);
      quiet_out = ($urandom_range(0, 2) == 0);

      stop_at = beats_sent + BEATS_PER_PHASE;
      while (beats_sent < stop_at) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          st = st_code_t'($urandom_range(0, slps_pkg::ST_MAX));
          send_beat(slps_pkg::KIND_SET, st);
          // status flipped away and back with no tick in between
          if ($urandom_range(0, 9) == 0) begin
            send_beat(slps_pkg::KIND_SET, st_code_t'($urandom_range(0, slps_pkg::ST_MAX)));
            send_beat(slps_pkg::KIND_SET, st);
          end
          repeat ($urandom_range(1, 40))
            send_beat(slps_pkg::KIND_TICK, st_code_t'($urandom_range(0, 31)));
        end else if (pick < 97) begin
          send_beat(1'($urandom_range(0, 1)), st_code_t'($urandom_range(0, 31)));
        end else begin
          wait_leds_idle();
        end
      end
    end

    wait_leds_idle();
    if (leds_sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/slps_pkg.sv
rtl/slps_cfg_regs.sv
rtl/slps_step.sv
rtl/status_led_pattern_sequencer.sv
dv/tb_status_led_pattern_sequencer.sv
